### rtl/core/gffrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gffrc_pkg;

  localparam int GRID_DIM   = 16;
  localparam int CELL_TOTAL = GRID_DIM * GRID_DIM;
  localparam int COORD_W    = $clog2(GRID_DIM);
  localparam int CELL_W     = $clog2(CELL_TOTAL);
  localparam int PTR_W      = CELL_W + 1;
  localparam int COUNT_W    = 9;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [CELL_W-1:0]  cell_t;
  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam count_t COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef struct packed {
    coord_t row;
    coord_t col;
  } qent_t;

  typedef struct packed {
    logic   start;
    coord_t row;
    coord_t col;
  } fill_cmd_t;

  typedef struct packed {
    logic   done;
    count_t count;
  } fill_res_t;

  function automatic cell_t cell_addr(coord_t row, coord_t col);
    cell_addr = CELL_W'(row) * CELL_W'(GRID_DIM) + CELL_W'(col);
  endfunction

endpackage

`default_nettype wire

### rtl/core/gffrc_fill.sv
`timescale 1ns / 1ps
`default_nettype none

module gffrc_fill
  import gffrc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire fill_cmd_t cmd,
  output logic           busy,
  output cell_t          obs_addr,
  input  wire logic      obs_q,
  output fill_res_t      res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SEED,
    S_POP,
    S_LOAD,
    S_PROBE,
    S_EVAL
  } state_t;

  state_t     state_r;
  cell_t      clr_idx_r;
  coord_t     seed_row_r;
  coord_t     seed_col_r;
  coord_t     cur_row_r;
  coord_t     cur_col_r;
  logic [1:0] dir_r;
  ptr_t       head_r;
  ptr_t       tail_r;
  count_t     tally_r;
  logic       done_r;
  count_t     count_r;

  logic vis_mem [CELL_TOTAL];
  qent_t q_mem [CELL_TOTAL];
  logic  vis_q;
  qent_t q_q;

  logic   vis_we;
  cell_t  vis_wa;
  logic   vis_wd;
  logic   q_we;
  cell_t  q_wa;
  qent_t  q_wd;
  cell_t  q_ra;

  coord_t nb_row;
  coord_t nb_col;
  logic   nb_ok;
  cell_t  nb_addr;
  logic   nb_free;

  always_comb begin
    nb_row = cur_row_r;
    nb_col = cur_col_r;
    nb_ok  = 1'b0;
    case (dir_r)
      DIR_UP: begin
        nb_row = cur_row_r - 1'b1;
        nb_ok  = (cur_row_r != '0);
      end
      DIR_DOWN: begin
        nb_row = cur_row_r + 1'b1;
        nb_ok  = (cur_row_r != coord_t'(GRID_DIM - 1));
      end
      DIR_LEFT: begin
        nb_col = cur_col_r - 1'b1;
        nb_ok  = (cur_col_r != '0);
      end
      DIR_RIGHT: begin
        nb_col = cur_col_r + 1'b1;
        nb_ok  = (cur_col_r != coord_t'(GRID_DIM - 1));
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
    nb_addr = cell_addr(nb_row, nb_col);
    nb_free = !vis_q && !obs_q;
  end

  always_comb begin
    vis_we = 1'b0;
    vis_wa = nb_addr;
    vis_wd = 1'b1;
    q_we   = 1'b0;
    q_wa   = tail_r[CELL_W-1:0];
    q_wd   = '{row: nb_row, col: nb_col};
    q_ra   = head_r[CELL_W-1:0];
    case (state_r)
      S_CLEAR: begin
        vis_we = 1'b1;
        vis_wa = clr_idx_r;
        vis_wd = 1'b0;
      end
      S_SEED: begin
        vis_we = 1'b1;
        vis_wa = cell_addr(seed_row_r, seed_col_r);
        q_we   = 1'b1;
        q_wa   = '0;
        q_wd   = '{row: seed_row_r, col: seed_col_r};
      end
      S_EVAL: begin
        vis_we = nb_free;
        q_we   = nb_free;
      end
      default: begin
        vis_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    vis_q <= vis_mem[nb_addr];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_wa] <= q_wd;
    end
    q_q <= q_mem[q_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      clr_idx_r <= '0;
      dir_r     <= DIR_UP;
      head_r    <= '0;
      tail_r    <= '0;
      tally_r   <= '0;
      done_r    <= 1'b0;
      count_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cmd.start) begin
            seed_row_r <= cmd.row;
            seed_col_r <= cmd.col;
            clr_idx_r  <= '0;
            state_r    <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == cell_t'(CELL_TOTAL - 1)) begin
            state_r <= S_SEED;
          end
        end
        S_SEED: begin
          head_r  <= '0;
          tail_r  <= ptr_t'(1);
          tally_r <= count_t'(1);
          state_r <= S_POP;
        end
        S_POP: begin
          if (head_r == tail_r) begin
            done_r  <= 1'b1;
            count_r <= tally_r;
            state_r <= S_IDLE;
          end else begin
            head_r  <= head_r + 1'b1;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          cur_row_r <= q_q.row;
          cur_col_r <= q_q.col;
          dir_r     <= DIR_UP;
          state_r   <= S_PROBE;
        end
        S_PROBE: begin
          if (nb_ok) begin
            state_r <= S_EVAL;
          end else if (dir_r == DIR_RIGHT) begin
            state_r <= S_POP;
          end else begin
            dir_r <= dir_r + 1'b1;
          end
        end
        S_EVAL: begin
          if (nb_free) begin
            tail_r <= tail_r + 1'b1;
            if (tally_r != COUNT_MAX) begin
              tally_r <= tally_r + 1'b1;
            end
          end
          if (dir_r == DIR_RIGHT) begin
            state_r <= S_POP;
          end else begin
            dir_r   <= dir_r + 1'b1;
            state_r <= S_PROBE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign obs_addr  = nb_addr;
  assign res.done  = done_r;
  assign res.count = count_r;

endmodule

`default_nettype wire

### rtl/core/grid_flood_fill_reach_count_top.sv
// Grid flood-fill reach counter.
// The block holds a 16 x 16 map of open and blocked cells. An input beat is
// taken at a rising edge where start is high and busy is low. A beat with
// in_kind low writes in_blocked into the cell at in_row, in_col; it gives no
// result and busy stays low, so writes can follow every cycle. A beat with
// in_kind high starts a four-way breadth-first fill from that cell and
// returns the number of cells reached, the start cell always included.
// The result beat shows on out_reach_count for one cycle with out_valid high
// and must be taken then; there is no way to hold it.
// A query from outside the grid returns zero in the next cycle. Otherwise
// busy rises for the whole fill: the visited map is cleared first, then each
// reached cell is dequeued and its four neighbors are probed in turn; a
// neighbor inside the grid also takes an evaluation step. The visited and queue
// memories have one read port each, and every neighbor probe waits on that
// read. The result appears in the first cycle with busy low, when the next
// beat may already be taken. After reset busy stays high while every cell of
// the map is written open; control state is cleared at reset.
`timescale 1ns / 1ps
`default_nettype none

module grid_flood_fill_reach_count_top
  import gffrc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire logic         in_kind,
  input  wire logic [3:0]   in_row,
  input  wire logic [3:0]   in_col,
  input  wire logic         in_blocked,
  output logic              out_valid,
  output logic [COUNT_W-1:0] out_reach_count
);

  logic      obs_mem [CELL_TOTAL];
  logic      obs_q;
  cell_t     obs_addr;
  logic      fill_busy;
  fill_cmd_t cmd;
  fill_res_t res;
  logic      accept;
  logic      in_grid;
  logic      oob_r;
  logic      init_r;
  cell_t     init_idx_r;
  logic      obs_we;
  cell_t     obs_wa;
  logic      obs_wd;

  assign accept  = start && !busy;
  assign in_grid = (int'(in_row) < GRID_DIM) && (int'(in_col) < GRID_DIM);

  assign cmd.start = accept && in_kind && in_grid;
  assign cmd.row   = coord_t'(in_row);
  assign cmd.col   = coord_t'(in_col);

  assign obs_we = init_r || (accept && !in_kind && in_grid);
  assign obs_wa = init_r ? init_idx_r : cell_addr(coord_t'(in_row), coord_t'(in_col));
  assign obs_wd = init_r ? 1'b0 : in_blocked;

  always_ff @(posedge clk) begin
    if (obs_we) begin
      obs_mem[obs_wa] <= obs_wd;
    end
    obs_q <= obs_mem[obs_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oob_r      <= 1'b0;
      init_r     <= 1'b1;
      init_idx_r <= '0;
    end else begin
      oob_r <= accept && in_kind && !in_grid;
      if (init_r) begin
        init_idx_r <= init_idx_r + 1'b1;
        if (init_idx_r == cell_t'(CELL_TOTAL - 1)) begin
          init_r <= 1'b0;
        end
      end
    end
  end

  gffrc_fill u_fill (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .busy     (fill_busy),
    .obs_addr (obs_addr),
    .obs_q    (obs_q),
    .res      (res)
  );

  assign busy            = fill_busy || init_r;
  assign out_valid       = res.done || oob_r;
  assign out_reach_count = oob_r ? '0 : res.count;

endmodule

`default_nettype wire

### tb/tb_grid_flood_fill_reach_count_top.sv
`timescale 1ns / 1ps

module tb_grid_flood_fill_reach_count_top;
  import gffrc_pkg::*;

  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_QUERY   = 1'b1;
  localparam int   KNOWN_NONE   = -1;
  localparam int   PLAN_ROWS    = 23;
  localparam int   RANDOM_BEATS = 580;
  localparam int   TAIL_CYCLES  = 3000;
  localparam longint RUN_LIMIT  = 8_000_000;

  typedef struct {
    logic   kind;
    coord_t row;
    coord_t col;
    logic   blk;
    int     known;
  } plan_row_t;

  logic         clk;
  logic         rst_n = 1'b0;
  logic         start = 1'b0;
  logic         in_kind = KIND_WRITE;
  logic [3:0]   in_row = '0;
  logic [3:0]   in_col = '0;
  logic         in_blocked = 1'b0;
  int           beat_known = KNOWN_NONE;
  logic         busy;
  logic         out_valid;
  count_t       out_reach_count;

  bit           cell_blocked [CELL_TOTAL];
  count_t       expected_counts [$];
  int           mismatch_count = 0;
  int           beats_sent = 0;
  int           burst_left = 0;
  longint       cycle_count = 0;

  plan_row_t directed_plan [PLAN_ROWS] = '{
    '{KIND_QUERY, 4'd0,  4'd0,  1'b0, 256},
    '{KIND_QUERY, 4'd15, 4'd15, 1'b1, 256},
    '{KIND_WRITE, 4'd0,  4'd1,  1'b1, KNOWN_NONE},
    '{KIND_WRITE, 4'd1,  4'd0,  1'b1, KNOWN_NONE},
    '{KIND_QUERY, 4'd0,  4'd0,  1'b0, 1},
    '{KIND_QUERY, 4'd15, 4'd15, 1'b0, KNOWN_NONE},
    '{KIND_WRITE, 4'd0,  4'd0,  1'b1, KNOWN_NONE},
    '{KIND_QUERY, 4'd0,  4'd0,  1'b1, 1},
    '{KIND_WRITE, 4'd0,  4'd1,  1'b0, KNOWN_NONE},
    '{KIND_QUERY, 4'd0,  4'd0,  1'b0, KNOWN_NONE},
    '{KIND_WRITE, 4'd15, 4'd14, 1'b1, KNOWN_NONE},
    '{KIND_WRITE, 4'd14, 4'd15, 1'b1, KNOWN_NONE},
    '{KIND_QUERY, 4'd15, 4'd15, 1'b0, 1},
    '{KIND_WRITE, 4'd7,  4'd7,  1'b1, KNOWN_NONE},
    '{KIND_WRITE, 4'd6,  4'd8,  1'b1, KNOWN_NONE},
    '{KIND_WRITE, 4'd8,  4'd8,  1'b1, KNOWN_NONE},
    '{KIND_WRITE, 4'd7,  4'd9,  1'b1, KNOWN_NONE},
    '{KIND_QUERY, 4'd7,  4'd8,  1'b1, 1},
    '{KIND_QUERY, 4'd7,  4'd7,  1'b0, KNOWN_NONE},
    '{KIND_QUERY, 4'd15, 4'd14, 1'b1, KNOWN_NONE},
    '{KIND_WRITE, 4'd15, 4'd15, 1'b1, KNOWN_NONE},
    '{KIND_QUERY, 4'd15, 4'd15, 1'b0, 1},
    '{KIND_QUERY, 4'd0,  4'd15, 1'b0, KNOWN_NONE}
  };

  grid_flood_fill_reach_count_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_blocked      (in_blocked),
    .out_valid       (out_valid),
    .out_reach_count (out_reach_count)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic count_t reach_from(coord_t r0, coord_t c0);
    bit          seen [CELL_TOTAL];
    int          frontier [$];
    int unsigned tally;
    int          here;
    int          r;
    int          c;
    int          nr;
    int          nc;
    int          next;
    foreach (seen[i]) seen[i] = 1'b0;
    here = int'(r0) * GRID_DIM + int'(c0);
    seen[here] = 1'b1;
    frontier.insert(frontier.size(), here);
    tally = 1;
    while (frontier.size() != 0) begin
      here = frontier.pop_front();
      r = here / GRID_DIM;
      c = here % GRID_DIM;
      for (int d = 0; d < 4; d++) begin
        nr = r;
        nc = c;
        case (2'(d))
          DIR_UP:    nr = r - 1;
          DIR_DOWN:  nr = r + 1;
          DIR_LEFT:  nc = c - 1;
          default:   nc = c + 1;
        endcase
        if (nr >= 0 && nr < GRID_DIM && nc >= 0 && nc < GRID_DIM) begin
          next = nr * GRID_DIM + nc;
          if (!seen[next] && !cell_blocked[next]) begin
            seen[next] = 1'b1;
            frontier.insert(frontier.size(), next);
            if (tally < COUNT_MAX) tally++;
          end
        end
      end
    end
    return count_t'(tally);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Results are checked before the beat taken at the same edge is predicted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (expected_counts.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", out_reach_count));
        end else if (out_reach_count !== expected_counts[0]) begin
          report_mismatch($sformatf("reach_count %0d, expected %0d",
                                    out_reach_count, expected_counts[0]));
          void'(expected_counts.pop_front());
        end else begin
          void'(expected_counts.pop_front());
        end
      end
      if (start && !busy) begin
        if (in_kind == KIND_WRITE) begin
          cell_blocked[int'(in_row) * GRID_DIM + int'(in_col)] = in_blocked;
        end else if (beat_known != KNOWN_NONE) begin
          expected_counts.insert(expected_counts.size(), count_t'(beat_known));
        end else begin
          expected_counts.insert(expected_counts.size(), reach_from(in_row, in_col));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_beat(input logic kind, input coord_t row, input coord_t col,
                           input logic blk, input int known);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    start      <= 1'b1;
    in_kind    <= kind;
    in_row     <= row;
    in_col     <= col;
    in_blocked <= blk;
    beat_known <= known;
    do @(posedge clk); while (busy);
    burst_left--;
    beats_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_counts.size() != 0) @(posedge clk);
  endtask

  initial begin
    int     style;
    int     n;
    int     line;
    int     gaps;
    int     g1;
    int     g2;
    int     density;
    bit     horiz;
    coord_t r;
    coord_t c;
    coord_t last_r;
    coord_t last_c;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      send_beat(directed_plan[i].kind, directed_plan[i].row, directed_plan[i].col,
                directed_plan[i].blk, directed_plan[i].known);
    end
    drain_results();

    while (beats_sent < PLAN_ROWS + RANDOM_BEATS) begin
      if ($urandom_range(0, 5) == 0) drain_results();
      style = $urandom_range(0, 9);
      last_r = 4'($urandom_range(0, 15));
      last_c = 4'($urandom_range(0, 15));
      if (style < 3) begin
        // A full wall across the map with up to two openings.
        horiz = 1'($urandom_range(0, 1));
        line = $urandom_range(0, 15);
        gaps = $urandom_range(0, 2);
        g1 = $urandom_range(0, 15);
        g2 = $urandom_range(0, 15);
        for (int i = 0; i < GRID_DIM; i++) begin
          r = horiz ? 4'(line) : 4'(i);
          c = horiz ? 4'(i) : 4'(line);
          send_beat(KIND_WRITE, r, c,
                    !((gaps >= 1 && i == g1) || (gaps >= 2 && i == g2)), KNOWN_NONE);
          last_r = r;
          last_c = c;
        end
        n = $urandom_range(2, 4);
      end else if (style < 6) begin
        density = $urandom_range(0, 100);
        n = $urandom_range(4, 24);
        repeat (n) begin
          last_r = 4'($urandom_range(0, 15));
          last_c = 4'($urandom_range(0, 15));
          send_beat(KIND_WRITE, last_r, last_c, $urandom_range(0, 99) < density,
                    KNOWN_NONE);
        end
        n = $urandom_range(1, 3);
      end else if (style < 8) begin
        n = $urandom_range(8, 30);
        repeat (n) begin
          send_beat(KIND_WRITE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                    1'b0, KNOWN_NONE);
        end
        n = $urandom_range(1, 2);
      end else begin
        n = $urandom_range(3, 10);
        repeat (n) begin
          send_beat(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                    4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), KNOWN_NONE);
        end
        n = 0;
      end
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) begin
          r = last_r;
          c = last_c;
        end else begin
          r = 4'($urandom_range(0, 15));
          c = 4'($urandom_range(0, 15));
        end
        send_beat(KIND_QUERY, r, c, 1'($urandom_range(0, 1)), KNOWN_NONE);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_counts.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
